// ===== rtl/biou_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biou_pkg
// Shared widths, constants and word types for the box intersection over
// union pipeline.
// ----------------------------------------------------------------------------
package biou_pkg;

    // coordinate and fraction widths
    localparam int COORD_WIDTH = 12;
    localparam int FRAC_BITS   = 16;

    // derived widths
    localparam int AREA_WIDTH  = 2 * COORD_WIDTH;
    localparam int UNION_WIDTH = AREA_WIDTH + 1;
    localparam int RATIO_WIDTH = FRAC_BITS + 1;
    localparam int DIV_STEPS   = FRAC_BITS + 1;

    // ratio value that stands for 1.0
    localparam logic [RATIO_WIDTH-1:0] RATIO_ONE = RATIO_WIDTH'(1) << FRAC_BITS;

    typedef logic [COORD_WIDTH-1:0] coord_t;
    typedef logic [AREA_WIDTH-1:0]  area_t;
    typedef logic [UNION_WIDTH-1:0] union_t;
    typedef logic [RATIO_WIDTH-1:0] ratio_t;

    // input word: two boxes
    typedef struct packed {
        coord_t a_left;
        coord_t a_top;
        coord_t a_right;
        coord_t a_bottom;
        coord_t b_left;
        coord_t b_top;
        coord_t b_right;
        coord_t b_bottom;
    } box_pair_t;

    // output word
    typedef struct packed {
        ratio_t iou_ratio;
        logic   union_zero;
    } iou_result_t;

    // handoff from the area stages to the divider
    typedef struct packed {
        area_t  inter;
        union_t union_sum;
        logic   union_zero;
    } div_req_t;

endpackage

// ===== rtl/biou_area.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biou_area
// Three register stages: box extents and overlap, the three area products,
// then the union sum and its zero flag.
// ----------------------------------------------------------------------------
module biou_area (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                boxes_valid,
    input  biou_pkg::box_pair_t boxes,
    output logic                req_valid,
    output biou_pkg::div_req_t  req
);

    // absolute difference of two coordinates
    function automatic biou_pkg::coord_t abs_diff(input biou_pkg::coord_t x,
                                                  input biou_pkg::coord_t y);
        biou_pkg::coord_t d;
        if (x >= y)
            d = x - y;
        else
            d = y - x;
        return d;
    endfunction

    // overlap of two intervals, clamped at zero
    function automatic biou_pkg::coord_t overlap(input biou_pkg::coord_t lo1,
                                                 input biou_pkg::coord_t hi1,
                                                 input biou_pkg::coord_t lo2,
                                                 input biou_pkg::coord_t hi2);
        biou_pkg::coord_t lo;
        biou_pkg::coord_t hi;
        biou_pkg::coord_t d;
        lo = (lo1 > lo2) ? lo1 : lo2;
        hi = (hi1 < hi2) ? hi1 : hi2;
        d  = (hi > lo) ? (hi - lo) : '0;
        return d;
    endfunction

    logic valid1_reg;
    logic valid2_reg;
    logic valid3_reg;

    biou_pkg::coord_t dxa_reg, dya_reg, dxb_reg, dyb_reg, ox_reg, oy_reg;
    biou_pkg::area_t  area_a_reg, area_b_reg, inter2_reg;
    biou_pkg::div_req_t req_reg;
    biou_pkg::div_req_t req_next;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid1_reg <= boxes_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    // union sum and zero flag
    always_comb
    begin
        req_next.inter      = inter2_reg;
        req_next.union_sum  = biou_pkg::union_t'(area_a_reg) + biou_pkg::union_t'(area_b_reg)
                              - biou_pkg::union_t'(inter2_reg);
        req_next.union_zero = (req_next.union_sum == '0);
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dxa_reg <= abs_diff(boxes.a_right, boxes.a_left);
            dya_reg <= abs_diff(boxes.a_bottom, boxes.a_top);
            dxb_reg <= abs_diff(boxes.b_right, boxes.b_left);
            dyb_reg <= abs_diff(boxes.b_bottom, boxes.b_top);
            ox_reg  <= overlap(boxes.a_left, boxes.a_right, boxes.b_left, boxes.b_right);
            oy_reg  <= overlap(boxes.a_top, boxes.a_bottom, boxes.b_top, boxes.b_bottom);

            area_a_reg <= biou_pkg::area_t'(dxa_reg) * biou_pkg::area_t'(dya_reg);
            area_b_reg <= biou_pkg::area_t'(dxb_reg) * biou_pkg::area_t'(dyb_reg);
            inter2_reg <= biou_pkg::area_t'(ox_reg) * biou_pkg::area_t'(oy_reg);

            req_reg <= req_next;
        end
    end

    assign req_valid = valid3_reg;
    assign req       = req_reg;

endmodule

// ===== rtl/biou_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biou_div
// Pipelined restoring divider: one quotient bit per register stage, giving
// floor(inter * 2^FRAC_BITS / union) in FRAC_BITS+1 stages.
// ----------------------------------------------------------------------------
module biou_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  req_valid,
    input  biou_pkg::div_req_t    req,
    output logic                  result_valid,
    output biou_pkg::iou_result_t result
);

    localparam int STEPS = biou_pkg::DIV_STEPS;
    localparam int UW    = biou_pkg::UNION_WIDTH;
    localparam int RW    = biou_pkg::RATIO_WIDTH;

    logic                  valid_reg [STEPS];
    logic [UW-1:0]         rem_reg   [STEPS];
    logic [UW-1:0]         den_reg   [STEPS];
    logic [RW-1:0]         quo_reg   [STEPS];
    logic                  zero_reg  [STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic          valid_in;
        logic [UW-1:0] rem_in;
        logic [UW-1:0] den_in;
        logic [RW-1:0] quo_in;
        logic          zero_in;
        logic [UW:0]   trial;
        logic          take;
        logic [UW:0]   diff;
        logic [UW-1:0] rem_next;
        logic [RW-1:0] quo_next;

        // stage inputs
        if (i == 0)
        begin : g_first
            assign valid_in = req_valid;
            assign rem_in   = UW'(req.inter);
            assign den_in   = req.union_sum;
            assign quo_in   = '0;
            assign zero_in  = req.union_zero;
            assign trial    = {1'b0, rem_in};
        end
        else
        begin : g_next
            assign valid_in = valid_reg[i-1];
            assign rem_in   = rem_reg[i-1];
            assign den_in   = den_reg[i-1];
            assign quo_in   = quo_reg[i-1];
            assign zero_in  = zero_reg[i-1];
            assign trial    = {rem_in, 1'b0};
        end

        // compare and subtract
        assign take     = (trial >= {1'b0, den_in});
        assign diff     = trial - {1'b0, den_in};
        assign rem_next = take ? diff[UW-1:0] : trial[UW-1:0];

        // last stage forces the ratio to zero on an empty union
        if (i == STEPS - 1)
        begin : g_last
            assign quo_next = zero_in ? '0 : {quo_in[RW-2:0], take};
        end
        else
        begin : g_mid
            assign quo_next = {quo_in[RW-2:0], take};
        end

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (advance)
                valid_reg[i] <= valid_in;
        end

        // payload
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_in;
                quo_reg[i]  <= quo_next;
                zero_reg[i] <= zero_in;
            end
        end
    end

    assign result_valid      = valid_reg[STEPS-1];
    assign result.iou_ratio  = quo_reg[STEPS-1];
    assign result.union_zero = zero_reg[STEPS-1];

endmodule

// ===== rtl/box_intersection_over_union.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_intersection_over_union
// Intersection over union of two axis-aligned boxes, fully pipelined.
// ----------------------------------------------------------------------------
// One box pair enters per clock unless boxes_stall is high: three stages
// form the extents, the area products and the union, then the restoring
// divider resolves one quotient bit per stage over FRAC_BITS + 1 stages. The
// whole pipeline moves as one; it holds only while a result word is shown
// and stalled, and then boxes_stall is high. The ratio is truncated,
// 1 << FRAC_BITS means 1.0, and an empty union gives union_zero with a zero
// ratio.
// ----------------------------------------------------------------------------
module box_intersection_over_union (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  boxes_valid,
    output logic                  boxes_stall,
    input  biou_pkg::box_pair_t   boxes,
    output logic                  result_valid,
    input  logic                  result_stall,
    output biou_pkg::iou_result_t result
);

    logic               advance;
    logic               req_valid;
    biou_pkg::div_req_t req;

    // pipeline moves unless the output word is held
    assign advance     = !(result_valid && result_stall);
    assign boxes_stall = !advance;

    // extents, areas and union
    biou_area u_area (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .boxes_valid (boxes_valid),
        .boxes       (boxes),
        .req_valid   (req_valid),
        .req         (req)
    );

    // fraction divider
    biou_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .req_valid    (req_valid),
        .req          (req),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== rtl/biou_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biou_checker
// Port-level checks on the box intersection over union block.
// ----------------------------------------------------------------------------
module biou_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  boxes_stall,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  biou_pkg::iou_result_t result
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // empty union reports a zero ratio
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.union_zero |-> result.iou_ratio == '0)
        else $error("nonzero ratio with empty union");

    // ratio never exceeds 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.iou_ratio <= biou_pkg::RATIO_ONE)
        else $error("ratio above one");

    // input held back only by a held output word
    assert property (@(posedge clk) disable iff (!rst_n)
        boxes_stall |-> result_valid && result_stall)
        else $error("input stalled without output backpressure");

endmodule

bind box_intersection_over_union biou_checker u_biou_checker (.*);
